// ===== rtl/vtp_pkg.sv =====
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared types and constants of the vertex transform pipeline.
// ----------------------------------------------------------------------------
package vtp_pkg;

  localparam int unsigned NumRegs   = 8;
  localparam int unsigned RegW      = 64;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned FracW     = 16;
  localparam int unsigned ProdW     = 2 * CoordW;
  localparam int unsigned SumW      = ProdW + 2;
  localparam int unsigned ShW       = SumW - FracW;
  localparam int unsigned DivW      = CoordW + FracW;
  localparam int unsigned AddrW     = 6;
  localparam int unsigned IdxW      = 3;
  localparam int unsigned IdxLsb    = 3;

  localparam logic signed [CoordW-1:0] S32Max = 32'sh7fff_ffff;
  localparam logic signed [CoordW-1:0] S32Min = 32'sh8000_0000;

  localparam logic [RegW-1:0] RegReset [NumRegs] = '{
    64'h0000_0000_0001_0000, 64'h0,
    64'h0001_0000_0000_0000, 64'h0,
    64'h0,                   64'h0000_0000_0001_0000,
    64'h0,                   64'h0001_0000_0000_0000
  };

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct packed {
    logic [2:0][DivW-1:0]   num;
    logic [2:0][CoordW-1:0] rem;
    logic [2:0]             neg;
    logic [2:0][CoordW-1:0] raw;
    logic [CoordW-1:0]      den;
    logic [CoordW-1:0]      w;
    logic                   wz;
    logic                   sat;
  } div_t;

endpackage

// ===== rtl/vtp_in_if.sv =====
// ----------------------------------------------------------------------------
// vtp_in_if
// Input vertex channel: valid/ready with x, y, z, w in Q16.16.
// ----------------------------------------------------------------------------
interface vtp_in_if import vtp_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t in_x;
  coord_t in_y;
  coord_t in_z;
  coord_t in_w;

  modport source (output valid, in_x, in_y, in_z, in_w, input ready);
  modport sink   (input valid, in_x, in_y, in_z, in_w, output ready);
endinterface

// ===== rtl/vtp_out_if.sv =====
// ----------------------------------------------------------------------------
// vtp_out_if
// Output vertex channel: valid/ready with transformed vertex and flags.
// ----------------------------------------------------------------------------
interface vtp_out_if import vtp_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t out_x;
  coord_t out_y;
  coord_t out_z;
  coord_t out_w;
  logic   w_zero;
  logic   saturated;

  modport source (output valid, out_x, out_y, out_z, out_w, w_zero, saturated,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_w, w_zero, saturated,
                  output ready);
endinterface

// ===== rtl/vertex_transform_project.sv =====
// ----------------------------------------------------------------------------
// vertex_transform_project
// 4x4 matrix times homogeneous vertex, then perspective divide by w.
//
//   channel   dir  handshake            word
//   vtx_in    in   valid/ready          in_x, in_y, in_z, in_w
//   vtx_out   out  valid/ready          out_x..out_w, w_zero, saturated
//   apb       in   psel/penable/pready  64-bit matrix registers at 8*i
//
// One vertex per cycle unless the output stalls. Stages: product stage,
// row sum stage, divide setup stage, 48 restoring divide stages (one
// quotient bit each) and the output stage.
// Reset clears valid bits and loads the identity matrix.
// A stalled output holds the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module vertex_transform_project import vtp_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  vtp_in_if.sink           vtx_in,
  vtp_out_if.source        vtx_out,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [RegW-1:0]  pwdata,
  output logic [RegW-1:0]  prdata,
  output logic             pready
);

  logic [RegW-1:0] cfg_q [NumRegs];
  logic [IdxW-1:0] cfg_idx;

  assign cfg_idx = paddr[IdxLsb +: IdxW];
  assign pready  = 1'b1;
  assign prdata  = cfg_q[cfg_idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) cfg_q[i] <= RegReset[i];
    end else if (psel && penable && pwrite) begin
      cfg_q[cfg_idx] <= pwdata;
    end
  end

  // pipeline enable
  logic en;
  logic out_vld_q;
  assign en           = !out_vld_q || vtx_out.ready;
  assign vtx_in.ready = en;

  // stage 1: products
  coord_t vin [4];
  assign vin[0] = vtx_in.in_x;
  assign vin[1] = vtx_in.in_y;
  assign vin[2] = vtx_in.in_z;
  assign vin[3] = vtx_in.in_w;

  logic signed [ProdW-1:0] prod_d [4][4];
  logic signed [ProdW-1:0] prod_q [4][4];
  logic                    vld1_q;

  for (genvar r = 0; r < 4; r++) begin : g_row
    for (genvar c = 0; c < 4; c++) begin : g_col
      coord_t coef;
      assign coef = cfg_q[r*2 + c/2][(c%2)*CoordW +: CoordW];
      assign prod_d[r][c] = ProdW'(coef) * ProdW'(vin[c]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) prod_q <= prod_d;
  end

  // stage 2: row sums, floor shift, clamp
  coord_t rsum_d [4];
  logic [3:0] rsat;
  coord_t rsum_q [4];
  logic   rsat_q;
  logic   vld2_q;

  always_comb begin
    logic signed [SumW-1:0] s;
    logic signed [ShW-1:0]  sh;
    for (int r = 0; r < 4; r++) begin
      s = SumW'(prod_q[r][0]) + SumW'(prod_q[r][1])
        + SumW'(prod_q[r][2]) + SumW'(prod_q[r][3]);
      sh = ShW'(s >>> FracW);
      rsat[r] = 1'b0;
      if (sh > ShW'(S32Max)) begin
        rsum_d[r] = S32Max;
        rsat[r] = 1'b1;
      end else if (sh < ShW'(S32Min)) begin
        rsum_d[r] = S32Min;
        rsat[r] = 1'b1;
      end else begin
        rsum_d[r] = CoordW'(sh);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rsum_q <= rsum_d;
      rsat_q <= |rsat;
    end
  end

  // stage 3: divide setup
  div_t dv_d [DivW+1];
  div_t dv_q [DivW+1];
  logic [DivW:0] dvld_q;

  always_comb begin
    logic signed [DivW-1:0] a;
    dv_d[0].den = rsum_q[3][CoordW-1] ? CoordW'(-rsum_q[3]) : rsum_q[3];
    dv_d[0].w   = rsum_q[3];
    dv_d[0].wz  = (rsum_q[3] == '0);
    dv_d[0].sat = rsat_q;
    for (int i = 0; i < 3; i++) begin
      a = {rsum_q[i], {FracW{1'b0}}};
      dv_d[0].num[i] = a[DivW-1] ? DivW'(-a) : a;
      dv_d[0].rem[i] = '0;
      dv_d[0].neg[i] = rsum_q[i][CoordW-1] ^ rsum_q[3][CoordW-1];
      dv_d[0].raw[i] = rsum_q[i];
    end
  end

  // restoring divide, one quotient bit per stage
  for (genvar k = 0; k < DivW; k++) begin : g_div
    always_comb begin
      logic [CoordW:0] t;
      dv_d[k+1] = dv_q[k];
      for (int i = 0; i < 3; i++) begin
        t = {dv_q[k].rem[i], dv_q[k].num[i][DivW-1]};
        if (t >= {1'b0, dv_q[k].den}) begin
          dv_d[k+1].rem[i] = CoordW'(t - {1'b0, dv_q[k].den});
          dv_d[k+1].num[i] = {dv_q[k].num[i][DivW-2:0], 1'b1};
        end else begin
          dv_d[k+1].rem[i] = CoordW'(t);
          dv_d[k+1].num[i] = {dv_q[k].num[i][DivW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) dv_q <= dv_d;
  end

  // output stage: sign, clamp, select
  coord_t qout [3];
  logic [2:0] qsat;

  always_comb begin
    logic [DivW-1:0] q;
    for (int i = 0; i < 3; i++) begin
      q = dv_q[DivW].num[i];
      qsat[i] = 1'b0;
      if (dv_q[DivW].wz) begin
        qout[i] = dv_q[DivW].raw[i];
      end else if (dv_q[DivW].neg[i]) begin
        if (q > DivW'(32'h8000_0000)) begin
          qout[i] = S32Min;
          qsat[i] = 1'b1;
        end else begin
          qout[i] = CoordW'(-q);
        end
      end else begin
        if (q > DivW'(32'h7fff_ffff)) begin
          qout[i] = S32Max;
          qsat[i] = 1'b1;
        end else begin
          qout[i] = CoordW'(q);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      vtx_out.out_x     <= qout[0];
      vtx_out.out_y     <= qout[1];
      vtx_out.out_z     <= qout[2];
      vtx_out.out_w     <= dv_q[DivW].w;
      vtx_out.w_zero    <= dv_q[DivW].wz;
      vtx_out.saturated <= dv_q[DivW].sat | (|qsat);
    end
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q    <= 1'b0;
      vld2_q    <= 1'b0;
      dvld_q    <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld1_q    <= vtx_in.valid;
      vld2_q    <= vld1_q;
      dvld_q    <= {dvld_q[DivW-1:0], vld2_q};
      out_vld_q <= dvld_q[DivW];
    end
  end

  assign vtx_out.valid = out_vld_q;

  a_wz_zero_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_out.valid && vtx_out.w_zero |-> vtx_out.out_w == '0)
    else $error("w_zero with nonzero w");

  a_nz_w: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vtx_out.valid && !vtx_out.w_zero |-> vtx_out.out_w != '0)
    else $error("divide done with zero w");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(dvld_q) && $stable(vld2_q))
    else $error("pipeline moved during stall");

endmodule

// ===== dv/tb_vertex_transform_project.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vertex_transform_project
// Self-checking bench for the vertex transform: a local model of the 4x4
// matrix product and perspective divide predicts every output word, which
// is compared field by field in order. Matrix registers are rewritten over
// the APB port between phases, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_vertex_transform_project;
  import vtp_pkg::*;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic        wz;
    logic        sat;
  } vertex_res_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [AddrW-1:0] paddr;
  logic [RegW-1:0] pwdata;
  logic [RegW-1:0] prdata;
  logic pready;

  vtp_in_if  vin ();
  vtp_out_if vout ();

  vertex_transform_project uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vtx_in  (vin),
    .vtx_out (vout),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  localparam int Latency = 52;

  logic [RegW-1:0] matrix_regs [NumRegs];
  vertex_res_t     expected_q [$];
  int  mismatches;
  int  words_seen;
  int  sent;
  bit  idle_en;
  bit  sink_idle_en;
  int  hold_cycles;
  bit  long_stall;
  event long_hold_ev;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  function automatic longint coeff(int row, int col);
    logic [RegW-1:0] r;
    r = matrix_regs[row * 2 + col / 2];
    return (col % 2) ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [127:0] v, ref bit sat);
    if (v > 128'sd2147483647) begin
      sat = 1;
      return 32'sh7fff_ffff;
    end
    if (v < -128'sd2147483648) begin
      sat = 1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic vertex_res_t transform_vertex(logic [31:0] x, logic [31:0] y,
                                                   logic [31:0] z, logic [31:0] w);
    logic signed [127:0] v [4];
    logic signed [127:0] acc;
    logic signed [127:0] q;
    logic signed [31:0]  r [4];
    vertex_res_t res;
    bit sat;
    sat = 0;
    v[0] = $signed(x);
    v[1] = $signed(y);
    v[2] = $signed(z);
    v[3] = $signed(w);
    for (int i = 0; i < 4; i++) begin
      acc = 0;
      for (int c = 0; c < 4; c++) acc += 128'(coeff(i, c)) * v[c];
      r[i] = clamp32(acc >>> 16, sat);
    end
    res.wz = (r[3] == 0);
    if (!res.wz) begin
      for (int i = 0; i < 3; i++) begin
        q = (128'(r[i]) * 128'sd65536) / 128'(r[3]);
        r[i] = clamp32(q, sat);
      end
    end
    res.x = r[0];
    res.y = r[1];
    res.z = r[2];
    res.w = r[3];
    res.sat = sat;
    return res;
  endfunction

  task automatic write_reg(int idx, logic [RegW-1:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx * 8);
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx < NumRegs) matrix_regs[idx] = val;
    @(posedge clk_i);
  endtask

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] w);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      vin.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    vin.valid <= 1'b1;
    vin.in_x  <= x;
    vin.in_y  <= y;
    vin.in_z  <= z;
    vin.in_w  <= w;
    @(posedge clk_i);
    while (!vin.ready) @(posedge clk_i);
    expected_q.push_back(transform_vertex(x, y, z, w));
    sent++;
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    vin.valid <= 1'b0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (Latency + 8) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 1) ? 32'h0001_0000 : 32'hffff_0000;
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      1: return 32'h0001_0000;
      2: return 32'h0;
      default: return $urandom();
    endcase
  endfunction

  task automatic load_random_matrix();
    for (int i = 0; i < NumRegs; i++) write_reg(i, {rand_coef(), rand_coef()});
  endtask

  task automatic test_identity_directed();
    send_vertex(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0001_0000);
    send_vertex(32'h0005_0000, 32'hfffb_0000, 32'h0001_8000, 32'h0);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001);
    send_vertex(32'hffff_ffff, 32'h0000_0001, 32'h8000_0000, 32'hffff_ffff);
    send_vertex(32'h0003_0000, 32'hfffd_0000, 32'h0001_0000, 32'h0002_0000);
    send_vertex(32'h0, 32'h0, 32'h0, 32'h8000_0000);
    send_vertex(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    drain();
  endtask

  task automatic test_extreme_matrix();
    for (int i = 0; i < NumRegs; i++) write_reg(i, 64'h7fff_ffff_7fff_ffff);
    send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(32'h0000_0001, 32'h0, 32'h0, 32'h0);
    drain();
    for (int i = 0; i < NumRegs; i++) write_reg(i, 64'h8000_0000_8000_0000);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'hffff_ffff);
    send_vertex(32'h0000_0002, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    drain();
    // w row tiny so quotients blow up
    write_reg(0, 64'h0000_0000_0100_0000);
    write_reg(1, 64'h0);
    write_reg(2, 64'h0100_0000_0000_0000);
    write_reg(3, 64'h0);
    write_reg(4, 64'h0);
    write_reg(5, 64'hffff_ffff_ffff_0000);
    write_reg(6, 64'h0);
    write_reg(7, 64'h0000_0001_0000_0000);
    send_vertex(32'h0100_0000, 32'hff00_0000, 32'h0001_0000, 32'h0001_0000);
    send_vertex(32'h0000_0001, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000);
    send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
    drain();
  endtask

  task automatic test_random_phases(int phases, int per_phase);
    for (int p = 0; p < phases; p++) begin
      load_random_matrix();
      for (int n = 0; n < per_phase; n++) begin
        if ($urandom_range(0, 9) == 0)
          send_vertex(rand_coord(), rand_coord(), rand_coord(), 32'h0);
        else
          send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      end
      drain();
    end
  endtask

  task automatic test_backpressure();
    -> long_hold_ev;
    for (int n = 0; n < 120; n++)
      send_vertex(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    drain();
  endtask

  // long receiver hold
  initial begin
    forever begin
      @(long_hold_ev);
      long_stall <= 1'b1;
      repeat (150) @(posedge clk_i);
      long_stall <= 1'b0;
    end
  end

  // output side: random stalls and one long hold
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      vout.ready <= 1'b0;
    end else if (long_stall) begin
      vout.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      vout.ready  <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
      vout.ready  <= 1'b0;
      hold_cycles <= $urandom_range(1, 10);
    end else begin
      vout.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    vertex_res_t exp_w;
    if (rst_ni && vout.valid && vout.ready) begin
      words_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word %0d", words_seen);
      end else begin
        exp_w = expected_q.pop_front();
        if (vout.out_x !== exp_w.x || vout.out_y !== exp_w.y || vout.out_z !== exp_w.z ||
            vout.out_w !== exp_w.w || vout.w_zero !== exp_w.wz ||
            vout.saturated !== exp_w.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("word %0d exp %h %h %h %h wz %b sat %b got %h %h %h %h wz %b sat %b",
                     words_seen, exp_w.x, exp_w.y, exp_w.z, exp_w.w, exp_w.wz, exp_w.sat,
                     vout.out_x, vout.out_y, vout.out_z, vout.out_w, vout.w_zero,
                     vout.saturated);
        end
      end
    end
  end

  initial begin
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    vin.valid = 0; vin.in_x = '0; vin.in_y = '0; vin.in_z = '0; vin.in_w = '0;
    vout.ready = 0;
    mismatches = 0; words_seen = 0; sent = 0; hold_cycles = 0;
    idle_en = 0; sink_idle_en = 0;
    for (int i = 0; i < NumRegs; i++) matrix_regs[i] = RegReset[i];
    rst_ni = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_identity_directed();
    test_extreme_matrix();
    idle_en = 1;
    sink_idle_en = 1;
    test_random_phases(8, 110);
    test_backpressure();
    idle_en = 0;
    sink_idle_en = 0;
    test_random_phases(2, 110);
    $display("sent %0d vertices over %0d matrix settings, checked %0d output words",
             sent, 14, words_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatches, expected_q.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
